### design/btac_pkg.sv
// Shared widths, constants and pipeline types of the bulge to arc center block.
`timescale 1ns / 1ps
`default_nettype none
package btac_pkg;

	localparam int COORD_WIDTH = 32;
	localparam int BULGE_W     = 32;
	localparam int THR_W       = 25;
	localparam logic [THR_W-1:0] THR_RESET = THR_W'(17);

	// Coordinate differences and their squares.
	localparam int DIFF_W = COORD_WIDTH + 1;
	localparam int SQ_W   = 2 * DIFF_W;
	localparam int ROOT_W = DIFF_W;
	localparam int REM_W  = ROOT_W + 2;

	// Bulge square, 1.0 squared in Q15.48, and the divisor B * 2^26.
	localparam int BSQ_W     = 2 * BULGE_W - 1;
	localparam int ONE_SHIFT = 48;
	localparam logic [BSQ_W-1:0] ONE_SQ = BSQ_W'(1) << ONE_SHIFT;
	localparam int DEN_SHIFT = 26;
	localparam int DEN_W     = BULGE_W + DEN_SHIFT;

	// Products are split into a low and a high partial product.
	localparam int MUL_LO_W = 32;
	localparam int MUL_HI_W = BSQ_W - MUL_LO_W;
	localparam int NUM_W    = DIFF_W + BSQ_W;

	// Quotient bits kept; anything larger saturates the center anyway.
	localparam int QUO_W      = COORD_WIDTH + 2;
	localparam int DIV_STAGES = QUO_W + 1;

	typedef struct packed {
		logic                   straight;
		logic                   neg;
		logic                   zero;
		logic                   oxneg;
		logic                   oyneg;
		logic [COORD_WIDTH-1:0] mid_x;
		logic [COORD_WIDTH-1:0] mid_y;
	} geo_t;

	typedef struct packed {
		geo_t              geo;
		logic [DIFF_W-1:0] adx;
		logic [DIFF_W-1:0] ady;
		logic [BSQ_W-1:0]  km;
		logic [BSQ_W-1:0]  fac;
		logic [DEN_W-1:0]  den;
	} sq_side_t;

endpackage
`default_nettype wire

### design/btac_seg_if.sv
// Segment input channel: valid, ready and the segment word.
`timescale 1ns / 1ps
`default_nettype none
interface btac_seg_if;
	logic                                        valid;
	logic                                        ready;
	logic signed [btac_pkg::COORD_WIDTH-1:0]     start_x;
	logic signed [btac_pkg::COORD_WIDTH-1:0]     start_y;
	logic signed [btac_pkg::COORD_WIDTH-1:0]     end_x;
	logic signed [btac_pkg::COORD_WIDTH-1:0]     end_y;
	logic signed [btac_pkg::BULGE_W-1:0]         bulge_value;

	modport source (output valid, start_x, start_y, end_x, end_y, bulge_value, input ready);
	modport sink (input valid, start_x, start_y, end_x, end_y, bulge_value, output ready);
endinterface
`default_nettype wire

### design/btac_arc_if.sv
// Arc result channel: valid, ready and the arc word.
`timescale 1ns / 1ps
`default_nettype none
interface btac_arc_if;
	logic                                    valid;
	logic                                    ready;
	logic signed [btac_pkg::COORD_WIDTH-1:0] ctr_x;
	logic signed [btac_pkg::COORD_WIDTH-1:0] ctr_y;
	logic [btac_pkg::COORD_WIDTH-2:0]        arc_radius;
	logic                                    is_straight;
	logic                                    counter_clockwise;
	logic                                    saturated;
	logic                                    zero_chord;

	modport source (output valid, ctr_x, ctr_y, arc_radius, is_straight,
		counter_clockwise, saturated, zero_chord, input ready);
	modport sink (input valid, ctr_x, ctr_y, arc_radius, is_straight,
		counter_clockwise, saturated, zero_chord, output ready);
endinterface
`default_nettype wire

### design/bulge_to_arc_center.sv
// Throughput: one segment word per cycle; the pipeline moves whenever the output
// register is empty or being taken. Depth is set by the 33 square root stages and
// the 35 divider stages. Reset clears all valid bits and sets thr_q to 17.
`timescale 1ns / 1ps
`default_nettype none
module bulge_to_arc_center (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wen,
	input  wire logic [btac_pkg::THR_W-1:0]    cfg_wdata,
	btac_seg_if.sink                           seg,
	btac_arc_if.source                         arc
);

	localparam int CW = btac_pkg::COORD_WIDTH;
	localparam int PAD_W = btac_pkg::QUO_W + 3 - CW;

	function automatic logic [CW:0] clip_center(
		input logic [CW-1:0]              mid,
		input logic [btac_pkg::QUO_W-1:0] off,
		input logic                       ovf,
		input logic                       oneg
	);
		logic signed [btac_pkg::QUO_W+1:0] c;
		logic signed [btac_pkg::QUO_W+1:0] hi;
		logic signed [btac_pkg::QUO_W+1:0] lo;
		logic [btac_pkg::QUO_W+1:0]        midx;
		logic [btac_pkg::QUO_W+1:0]        offx;
		logic [CW:0]                       res;
		midx = {{(btac_pkg::QUO_W+2-CW){mid[CW-1]}}, mid};
		offx = {2'b00, off};
		hi   = {{PAD_W{1'b0}}, {(CW-1){1'b1}}};
		lo   = {{PAD_W{1'b1}}, {(CW-1){1'b0}}};
		c    = oneg ? (midx - offx) : (midx + offx);
		if (ovf) begin
			res = oneg ? {1'b1, 1'b1, {(CW-1){1'b0}}} : {1'b1, 1'b0, {(CW-1){1'b1}}};
		end else if (c > hi) begin
			res = {1'b1, 1'b0, {(CW-1){1'b1}}};
		end else if (c < lo) begin
			res = {1'b1, 1'b1, {(CW-1){1'b0}}};
		end else begin
			res = {1'b0, c[CW-1:0]};
		end
		return res;
	endfunction

	logic [btac_pkg::THR_W-1:0] thr_q;
	logic                       adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= btac_pkg::THR_RESET;
		end else if (cfg_wen) begin
			thr_q <= cfg_wdata;
		end
	end

	assign adv       = !arc.valid || arc.ready;
	assign seg.ready = adv;

	// Stage 1: bulge magnitude, line test, differences and midpoints.
	logic [btac_pkg::BULGE_W-1:0] braw_c, bm_c;
	logic                         neg_c, straight_c;
	logic [btac_pkg::DIFF_W-1:0]  dx_c, dy_c, adx_c, ady_c, sumx_c, sumy_c;

	assign braw_c     = seg.bulge_value;
	assign neg_c      = braw_c[btac_pkg::BULGE_W-1];
	assign bm_c       = neg_c ? (~braw_c + btac_pkg::BULGE_W'(1)) : braw_c;
	assign straight_c = (bm_c == '0) || (bm_c < btac_pkg::BULGE_W'(thr_q));
	assign dx_c   = {seg.end_x[CW-1], seg.end_x} - {seg.start_x[CW-1], seg.start_x};
	assign dy_c   = {seg.end_y[CW-1], seg.end_y} - {seg.start_y[CW-1], seg.start_y};
	assign adx_c  = dx_c[CW] ? (~dx_c + btac_pkg::DIFF_W'(1)) : dx_c;
	assign ady_c  = dy_c[CW] ? (~dy_c + btac_pkg::DIFF_W'(1)) : dy_c;
	assign sumx_c = {seg.start_x[CW-1], seg.start_x} + {seg.end_x[CW-1], seg.end_x};
	assign sumy_c = {seg.start_y[CW-1], seg.start_y} + {seg.end_y[CW-1], seg.end_y};

	logic                         v_s1, neg_s1, straight_s1, dxneg_s1, dypos_s1;
	logic [btac_pkg::BULGE_W-1:0] bm_s1;
	logic [btac_pkg::DIFF_W-1:0]  adx_s1, ady_s1;
	logic [CW-1:0]                midx_s1, midy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= seg.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			neg_s1      <= neg_c;
			straight_s1 <= straight_c;
			bm_s1       <= bm_c;
			adx_s1      <= adx_c;
			ady_s1      <= ady_c;
			dxneg_s1    <= dx_c[CW];
			dypos_s1    <= !dy_c[CW] && (dy_c != '0);
			// Dropping the low bit of the sum rounds the midpoint toward minus infinity.
			midx_s1     <= sumx_c[CW:1];
			midy_s1     <= sumy_c[CW:1];
		end
	end

	// Stage 2: squares.
	logic [2*btac_pkg::BULGE_W-1:0] bsq_c;
	logic                           v_s2, neg_s2, straight_s2, dxneg_s2, dypos_s2;
	logic [btac_pkg::BULGE_W-1:0]   bm_s2;
	logic [btac_pkg::DIFF_W-1:0]    adx_s2, ady_s2;
	logic [CW-1:0]                  midx_s2, midy_s2;
	logic [btac_pkg::SQ_W-1:0]      ax2_s2, ay2_s2;
	logic [btac_pkg::BSQ_W-1:0]     bsq_s2;

	assign bsq_c = {{btac_pkg::BULGE_W{1'b0}}, bm_s1} * {{btac_pkg::BULGE_W{1'b0}}, bm_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			neg_s2      <= neg_s1;
			straight_s2 <= straight_s1;
			dxneg_s2    <= dxneg_s1;
			dypos_s2    <= dypos_s1;
			bm_s2       <= bm_s1;
			adx_s2      <= adx_s1;
			ady_s2      <= ady_s1;
			midx_s2     <= midx_s1;
			midy_s2     <= midy_s1;
			ax2_s2      <= {{btac_pkg::DIFF_W{1'b0}}, adx_s1} *
				{{btac_pkg::DIFF_W{1'b0}}, adx_s1};
			ay2_s2      <= {{btac_pkg::DIFF_W{1'b0}}, ady_s1} *
				{{btac_pkg::DIFF_W{1'b0}}, ady_s1};
			bsq_s2      <= bsq_c[btac_pkg::BSQ_W-1:0];
		end
	end

	// Stage 3: chord square, (1 - b^2) and (1 + b^2) factors, offset signs.
	logic                  kneg_c;
	btac_pkg::sq_side_t    side_c;
	logic [btac_pkg::SQ_W-1:0] d2_s3;

	assign kneg_c = bsq_s2 > btac_pkg::ONE_SQ;

	always_comb begin
		side_c.geo.straight = straight_s2;
		side_c.geo.neg      = neg_s2;
		side_c.geo.zero     = (adx_s2 == '0) && (ady_s2 == '0);
		side_c.geo.oxneg    = dypos_s2 ^ kneg_c ^ neg_s2;
		side_c.geo.oyneg    = dxneg_s2 ^ kneg_c ^ neg_s2;
		side_c.geo.mid_x    = midx_s2;
		side_c.geo.mid_y    = midy_s2;
		side_c.adx          = adx_s2;
		side_c.ady          = ady_s2;
		side_c.km           = kneg_c ? (bsq_s2 - btac_pkg::ONE_SQ) : (btac_pkg::ONE_SQ - bsq_s2);
		side_c.fac          = bsq_s2 + btac_pkg::ONE_SQ;
		side_c.den          = {bm_s2, {btac_pkg::DEN_SHIFT{1'b0}}};
	end

	// Element 0 of these lines is the stage 3 register; the rest run beside the root.
	logic               sq_v_s    [0:btac_pkg::ROOT_W];
	btac_pkg::sq_side_t sq_side_s [0:btac_pkg::ROOT_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_v_s[0] <= 1'b0;
		end else if (adv) begin
			sq_v_s[0] <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_side_s[0] <= side_c;
			d2_s3        <= ax2_s2 + ay2_s2;
		end
	end

	for (genvar k = 1; k <= btac_pkg::ROOT_W; k++) begin : g_sq_line
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v_s[k] <= 1'b0;
			end else if (adv) begin
				sq_v_s[k] <= sq_v_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sq_side_s[k] <= sq_side_s[k-1];
			end
		end
	end

	logic [btac_pkg::ROOT_W-1:0] chord;

	btac_sqrt u_sqrt (
		.clk      (clk),
		.en       (adv),
		.radicand (d2_s3),
		.root     (chord)
	);

	// Stage 4: partial products of the three numerators.
	btac_pkg::sq_side_t sq_end;
	logic               v_s4;
	btac_pkg::geo_t     geo_s4;
	logic [btac_pkg::DEN_W-1:0] den_s4;
	logic [btac_pkg::DIFF_W+btac_pkg::MUL_LO_W-1:0] pr0_s4, px0_s4, py0_s4;
	logic [btac_pkg::DIFF_W+btac_pkg::MUL_HI_W-1:0] pr1_s4, px1_s4, py1_s4;

	assign sq_end = sq_side_s[btac_pkg::ROOT_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= sq_v_s[btac_pkg::ROOT_W];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			geo_s4 <= sq_end.geo;
			den_s4 <= sq_end.den;
			pr0_s4 <= {{btac_pkg::MUL_LO_W{1'b0}}, chord} *
				{{btac_pkg::DIFF_W{1'b0}}, sq_end.fac[btac_pkg::MUL_LO_W-1:0]};
			pr1_s4 <= {{btac_pkg::MUL_HI_W{1'b0}}, chord} *
				{{btac_pkg::DIFF_W{1'b0}}, sq_end.fac[btac_pkg::BSQ_W-1:btac_pkg::MUL_LO_W]};
			px0_s4 <= {{btac_pkg::MUL_LO_W{1'b0}}, sq_end.ady} *
				{{btac_pkg::DIFF_W{1'b0}}, sq_end.km[btac_pkg::MUL_LO_W-1:0]};
			px1_s4 <= {{btac_pkg::MUL_HI_W{1'b0}}, sq_end.ady} *
				{{btac_pkg::DIFF_W{1'b0}}, sq_end.km[btac_pkg::BSQ_W-1:btac_pkg::MUL_LO_W]};
			py0_s4 <= {{btac_pkg::MUL_LO_W{1'b0}}, sq_end.adx} *
				{{btac_pkg::DIFF_W{1'b0}}, sq_end.km[btac_pkg::MUL_LO_W-1:0]};
			py1_s4 <= {{btac_pkg::MUL_HI_W{1'b0}}, sq_end.adx} *
				{{btac_pkg::DIFF_W{1'b0}}, sq_end.km[btac_pkg::BSQ_W-1:btac_pkg::MUL_LO_W]};
		end
	end

	// Stage 5: numerators; element 0 of the divider side line is this stage.
	logic                       dv_v_s   [0:btac_pkg::DIV_STAGES];
	btac_pkg::geo_t             dv_geo_s [0:btac_pkg::DIV_STAGES];
	logic [btac_pkg::DEN_W-1:0] den_s5;
	logic [btac_pkg::NUM_W-1:0] numr_s5, numx_s5, numy_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v_s[0] <= 1'b0;
		end else if (adv) begin
			dv_v_s[0] <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dv_geo_s[0] <= geo_s4;
			den_s5      <= den_s4;
			numr_s5     <= btac_pkg::NUM_W'(pr0_s4) + {pr1_s4, {btac_pkg::MUL_LO_W{1'b0}}};
			numx_s5     <= btac_pkg::NUM_W'(px0_s4) + {px1_s4, {btac_pkg::MUL_LO_W{1'b0}}};
			numy_s5     <= btac_pkg::NUM_W'(py0_s4) + {py1_s4, {btac_pkg::MUL_LO_W{1'b0}}};
		end
	end

	for (genvar k = 1; k <= btac_pkg::DIV_STAGES; k++) begin : g_dv_line
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[k] <= 1'b0;
			end else if (adv) begin
				dv_v_s[k] <= dv_v_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_geo_s[k] <= dv_geo_s[k-1];
			end
		end
	end

	logic [btac_pkg::QUO_W-1:0] quo_r, quo_x, quo_y;
	logic                       ovf_r, ovf_x, ovf_y;

	btac_div u_div_r (.clk(clk), .en(adv), .num(numr_s5), .den(den_s5), .quo(quo_r), .ovf(ovf_r));
	btac_div u_div_x (.clk(clk), .en(adv), .num(numx_s5), .den(den_s5), .quo(quo_x), .ovf(ovf_x));
	btac_div u_div_y (.clk(clk), .en(adv), .num(numy_s5), .den(den_s5), .quo(quo_y), .ovf(ovf_y));

	// Output stage: center placement, clipping and the special cases.
	btac_pkg::geo_t geo_end;
	logic           rad_sat;
	logic [CW:0]    cx_c, cy_c;
	logic [CW-2:0]  rad_c;

	assign geo_end = dv_geo_s[btac_pkg::DIV_STAGES];
	assign rad_sat = ovf_r || (quo_r[btac_pkg::QUO_W-1:CW-1] != '0);
	assign rad_c   = rad_sat ? {(CW-1){1'b1}} : quo_r[CW-2:0];
	assign cx_c    = clip_center(geo_end.mid_x, quo_x, ovf_x, geo_end.oxneg);
	assign cy_c    = clip_center(geo_end.mid_y, quo_y, ovf_y, geo_end.oyneg);

	logic          out_v_q;
	logic [CW-1:0] cx_q, cy_q;
	logic [CW-2:0] rad_q;
	logic          straight_q, ccw_q, sat_q, zero_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= dv_v_s[btac_pkg::DIV_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			straight_q <= geo_end.straight;
			ccw_q      <= !geo_end.straight && !geo_end.neg;
			zero_q     <= !geo_end.straight && geo_end.zero;
			if (geo_end.straight || geo_end.zero) begin
				cx_q  <= '0;
				cy_q  <= '0;
				rad_q <= '0;
				sat_q <= 1'b0;
			end else begin
				cx_q  <= cx_c[CW-1:0];
				cy_q  <= cy_c[CW-1:0];
				rad_q <= rad_c;
				sat_q <= rad_sat || cx_c[CW] || cy_c[CW];
			end
		end
	end

	assign arc.valid             = out_v_q;
	assign arc.ctr_x             = cx_q;
	assign arc.ctr_y             = cy_q;
	assign arc.arc_radius        = rad_q;
	assign arc.is_straight       = straight_q;
	assign arc.counter_clockwise = ccw_q;
	assign arc.saturated         = sat_q;
	assign arc.zero_chord        = zero_q;

endmodule
`default_nettype wire

### design/btac_sqrt.sv
// Pipelined integer square root, one root bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module btac_sqrt (
	input  wire logic                          clk,
	input  wire logic                          en,
	input  wire logic [btac_pkg::SQ_W-1:0]     radicand,
	output logic      [btac_pkg::ROOT_W-1:0]   root
);

	logic [btac_pkg::REM_W-1:0]  rem_s  [1:btac_pkg::ROOT_W];
	logic [btac_pkg::ROOT_W-1:0] root_s [1:btac_pkg::ROOT_W];
	logic [btac_pkg::SQ_W-1:0]   rad_s  [1:btac_pkg::ROOT_W];

	for (genvar k = 0; k < btac_pkg::ROOT_W; k++) begin : g_step
		logic [btac_pkg::REM_W-1:0]  rem_in;
		logic [btac_pkg::ROOT_W-1:0] root_in;
		logic [btac_pkg::SQ_W-1:0]   rad_in;
		logic [btac_pkg::REM_W+1:0]  cur;
		logic [btac_pkg::REM_W+1:0]  trial;
		logic                        ge;

		if (k == 0) begin : g_first
			assign rem_in  = '0;
			assign root_in = '0;
			assign rad_in  = radicand;
		end else begin : g_next
			assign rem_in  = rem_s[k];
			assign root_in = root_s[k];
			assign rad_in  = rad_s[k];
		end

		// Bring down the next two radicand bits and try root*4+1.
		assign cur   = {rem_in, rad_in[btac_pkg::SQ_W-1 -: 2]};
		assign trial = {2'b00, root_in, 2'b01};
		assign ge    = (cur >= trial);

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= ge ? btac_pkg::REM_W'(cur - trial) : cur[btac_pkg::REM_W-1:0];
				root_s[k+1] <= {root_in[btac_pkg::ROOT_W-2:0], ge};
				rad_s[k+1]  <= {rad_in[btac_pkg::SQ_W-3:0], 2'b00};
			end
		end
	end

	assign root = root_s[btac_pkg::ROOT_W];

endmodule
`default_nettype wire

### design/btac_div.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow detect.
`timescale 1ns / 1ps
`default_nettype none
module btac_div (
	input  wire logic                         clk,
	input  wire logic                         en,
	input  wire logic [btac_pkg::NUM_W-1:0]   num,
	input  wire logic [btac_pkg::DEN_W-1:0]   den,
	output logic      [btac_pkg::QUO_W-1:0]   quo,
	output logic                              ovf
);

	logic [btac_pkg::DEN_W-1:0] rem_s  [0:btac_pkg::QUO_W];
	logic [btac_pkg::QUO_W-1:0] bits_s [0:btac_pkg::QUO_W];
	logic [btac_pkg::DEN_W-1:0] den_s  [0:btac_pkg::QUO_W];
	logic                       ovf_s  [0:btac_pkg::QUO_W];

	// The quotient fits in QUO_W bits exactly when the upper numerator part is below the divisor.
	always_ff @(posedge clk) begin
		if (en) begin
			ovf_s[0]  <= num[btac_pkg::NUM_W-1:btac_pkg::QUO_W] >=
				(btac_pkg::NUM_W - btac_pkg::QUO_W)'(den);
			rem_s[0]  <= num[btac_pkg::QUO_W+btac_pkg::DEN_W-1:btac_pkg::QUO_W];
			bits_s[0] <= num[btac_pkg::QUO_W-1:0];
			den_s[0]  <= den;
		end
	end

	for (genvar k = 0; k < btac_pkg::QUO_W; k++) begin : g_step
		logic [btac_pkg::DEN_W:0] cur;
		logic                     ge;

		assign cur = {rem_s[k], bits_s[k][btac_pkg::QUO_W-1]};
		assign ge  = (cur >= {1'b0, den_s[k]});

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= ge ? btac_pkg::DEN_W'(cur - {1'b0, den_s[k]})
					: cur[btac_pkg::DEN_W-1:0];
				bits_s[k+1] <= {bits_s[k][btac_pkg::QUO_W-2:0], ge};
				den_s[k+1]  <= den_s[k];
				ovf_s[k+1]  <= ovf_s[k];
			end
		end
	end

	assign quo = bits_s[btac_pkg::QUO_W];
	assign ovf = ovf_s[btac_pkg::QUO_W];

endmodule
`default_nettype wire

### dv/bulge_to_arc_center_test.sv
// Testbench for bulge_to_arc_center: random and directed segments checked against a predictor.
`timescale 1ns / 1ps
`default_nettype none
module bulge_to_arc_center_test;

	localparam int CW = btac_pkg::COORD_WIDTH;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 100;

	typedef struct packed {
		logic signed [CW-1:0] cx;
		logic signed [CW-1:0] cy;
		logic [CW-2:0]        rad;
		logic                 straight;
		logic                 ccw;
		logic                 sat;
		logic                 zero;
	} arc_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wen = 1'b0;
	logic [btac_pkg::THR_W-1:0] cfg_wdata = '0;

	btac_seg_if seg ();
	btac_arc_if arc ();

	bulge_to_arc_center u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
		.seg(seg.sink), .arc(arc.source)
	);

	always #5 clk = ~clk;

	logic [btac_pkg::THR_W-1:0] thr_model = btac_pkg::THR_RESET;
	arc_word_t arcs_pending[$];
	int mismatches = 0;
	int idle_cycles = 0;
	bit timed_out = 1'b0;
	bit sink_idles = 1'b1;
	bit src_idles = 1'b1;

	// floor(num / den) clipped to lim.
	function automatic logic [127:0] div_lim(logic [127:0] num, logic [127:0] den,
			logic [127:0] lim, ref bit clip);
		logic [127:0] q;
		q = num / den;
		if (q > lim) begin
			clip = 1'b1;
			return lim;
		end
		return q;
	endfunction

	function automatic logic signed [127:0] clamp_center(logic signed [127:0] a,
			logic signed [127:0] b, logic [127:0] off, bit offneg, ref bit sat);
		logic signed [127:0] s, m, c, cmax, cmin;
		s = a + b;
		m = s >>> 1;
		c = offneg ? m - $signed(off) : m + $signed(off);
		cmax = (128'sd1 <<< (CW - 1)) - 1;
		cmin = -cmax - 1;
		if (c > cmax) begin
			sat = 1'b1;
			return cmax;
		end
		if (c < cmin) begin
			sat = 1'b1;
			return cmin;
		end
		return c;
	endfunction

	function automatic arc_word_t arc_of_segment(logic signed [CW-1:0] x0,
			logic signed [CW-1:0] y0, logic signed [CW-1:0] x1,
			logic signed [CW-1:0] y1, logic [31:0] braw);
		arc_word_t r;
		logic [127:0] bm, bsq, den, km, d2, d, adx, ady, ox, oy, rad, cand;
		logic signed [127:0] dx, dy, cx, cy;
		bit neg, kneg, sat, oxneg, oyneg;
		r = '0;
		sat = 1'b0;
		neg = braw[31];
		bm = neg ? 128'(32'(-braw)) : 128'(braw);
		if (neg && bm == 0) bm = 128'h8000_0000;
		if (bm == 0 || bm < thr_model) begin
			r.straight = 1'b1;
			return r;
		end
		r.ccw = !neg;
		dx = 128'(x1) - 128'(x0);
		dy = 128'(y1) - 128'(y0);
		if (dx == 0 && dy == 0) begin
			r.zero = 1'b1;
			return r;
		end
		adx = dx < 0 ? -dx : dx;
		ady = dy < 0 ? -dy : dy;
		bsq = bm * bm;
		den = bm << 26;
		d2 = adx * adx + ady * ady;
		d = 0;
		for (int i = 63; i >= 0; i--) begin
			cand = d | (128'd1 << i);
			if (cand * cand <= d2) d = cand;
		end
		rad = div_lim(d * (bsq + (128'd1 << 48)), den, (128'd1 << (CW - 1)) - 1, sat);
		kneg = bsq > (128'd1 << 48);
		km = kneg ? bsq - (128'd1 << 48) : (128'd1 << 48) - bsq;
		ox = div_lim(ady * km, den, 128'd1 << 62, sat);
		oy = div_lim(adx * km, den, 128'd1 << 62, sat);
		oxneg = (dy > 0) != kneg;
		oyneg = (dx < 0) != kneg;
		if (neg) begin
			oxneg = !oxneg;
			oyneg = !oyneg;
		end
		cx = clamp_center(128'(x0), 128'(x1), ox, oxneg, sat);
		cy = clamp_center(128'(y0), 128'(y1), oy, oyneg, sat);
		r.cx = cx[CW-1:0];
		r.cy = cy[CW-1:0];
		r.rad = rad[CW-2:0];
		r.sat = sat;
		return r;
	endfunction

	initial begin
		seg.valid = 1'b0;
		seg.start_x = '0;
		seg.start_y = '0;
		seg.end_x = '0;
		seg.end_y = '0;
		seg.bulge_value = '0;
		arc.ready = 1'b0;
	end

	// Output ready with random stall bursts.
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (sink_idles && $urandom_range(0, 5) == 0) begin
				arc.ready <= 1'b0;
				n = $urandom_range(1, 11);
				repeat (n - 1) @(negedge clk);
			end else begin
				arc.ready <= 1'b1;
			end
		end
	end

	// Result checker and watchdog.
	always @(posedge clk) begin
		arc_word_t got, want;
		if (arst_n) begin
			if ((seg.valid && seg.ready) || (arc.valid && arc.ready)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (arc.valid && arc.ready) begin
				got = '{arc.ctr_x, arc.ctr_y, arc.arc_radius, arc.is_straight,
					arc.counter_clockwise, arc.saturated, arc.zero_chord};
				if (arcs_pending.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected arc word %p", got);
				end else begin
					want = arcs_pending.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("arc mismatch: expected %p, got %p", want, got);
					end
				end
			end
		end
	end

	task automatic send_segment(logic signed [CW-1:0] x0, logic signed [CW-1:0] y0,
			logic signed [CW-1:0] x1, logic signed [CW-1:0] y1, logic [31:0] b);
		int n;
		if (src_idles && $urandom_range(0, 5) == 0) begin
			n = $urandom_range(1, 11);
			seg.valid <= 1'b0;
			repeat (n) @(negedge clk);
		end
		seg.valid <= 1'b1;
		seg.start_x <= x0;
		seg.start_y <= y0;
		seg.end_x <= x1;
		seg.end_y <= y1;
		seg.bulge_value <= b;
		arcs_pending = {arcs_pending, arc_of_segment(x0, y0, x1, y1, b)};
		@(posedge clk);
		while (!seg.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain_pipeline();
		seg.valid <= 1'b0;
		while (arcs_pending.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic set_threshold(logic [btac_pkg::THR_W-1:0] v);
		drain_pipeline();
		cfg_wen <= 1'b1;
		cfg_wdata <= v;
		thr_model = v;
		@(negedge clk);
		cfg_wen <= 1'b0;
	endtask

	function automatic logic [31:0] rand_bulge();
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return $urandom_range(0, 32'h0200_0000);
			2: return -$urandom_range(0, 32'h0200_0000);
			3: return 32'h0100_0000 + $urandom_range(0, 255) - 128;
			4: return $urandom_range(0, 64);
			default: return $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
		endcase
	endfunction

	function automatic logic [CW-1:0] rand_coord();
		case ($urandom_range(0, 3))
			0: return $urandom();
			1: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
			2: return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom())};
			default: return $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
		endcase
	endfunction

	task automatic test_directed();
		logic [31:0] bulges[8] = '{32'h0, 32'h8000_0000, 32'h7fff_ffff, 32'h0100_0000,
			32'hff00_0000, 32'h0000_0011, 32'h0000_0010, 32'hffff_ffef};
		foreach (bulges[i])
			send_segment(32'h0001_0000, 32'hfffe_0000, 32'h0005_0000, 32'h0003_0000, bulges[i]);
		// Coincident endpoints, both bulge signs.
		send_segment(32'h1234_5678, 32'h8765_4321, 32'h1234_5678, 32'h8765_4321, 32'h0080_0000);
		send_segment(32'h0, 32'h0, 32'h0, 32'h0, 32'hff80_0000);
		// Extreme coordinates that push the center and radius into saturation.
		send_segment(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h0000_0100);
		send_segment(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
		send_segment(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'hffff_ff00);
		send_segment(32'h0, 32'h0, 32'h0000_0001, 32'h0, 32'h0000_0011);
		send_segment(32'hffff_ffff, 32'hffff_ffff, 32'h0, 32'h0, 32'h7fff_ffff);
	endtask

	task automatic test_threshold_settings();
		logic [btac_pkg::THR_W-1:0] thrs[4] = '{25'd0, 25'h100_0000, 25'h1ff_ffff, 25'd17};
		foreach (thrs[i]) begin
			set_threshold(thrs[i]);
			send_segment(32'h0, 32'h0, 32'h0002_0000, 32'h0001_0000, 32'h0);
			send_segment(32'h0, 32'h0, 32'h0002_0000, 32'h0001_0000, 32'h00ff_ffff);
			send_segment(32'h0, 32'h0, 32'h0002_0000, 32'h0001_0000, 32'h0100_0000);
			send_segment(32'h0, 32'h0, 32'h0002_0000, 32'h0001_0000, 32'hff00_0000);
			send_segment(32'h0, 32'h0, 32'h0002_0000, 32'h0001_0000, 32'h0000_0001);
		end
	endtask

	task automatic test_random(int count);
		logic [CW-1:0] x0, y0;
		for (int i = 0; i < count; i++) begin
			x0 = rand_coord();
			y0 = rand_coord();
			if ($urandom_range(0, 30) == 0)
				send_segment(x0, y0, x0, y0, rand_bulge());
			else
				send_segment(x0, y0, rand_coord(), rand_coord(), rand_bulge());
		end
	endtask

	task automatic test_back_to_back(int count);
		src_idles = 1'b0;
		sink_idles = 1'b0;
		test_random(count);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_threshold_settings();
		set_threshold(btac_pkg::THR_W'($urandom_range(0, 25'h100_0000)));
		test_random(400);
		set_threshold(25'd17);
		test_random(500);
		test_back_to_back(300);
		drain_pipeline();
		if (mismatches == 0) $display("bulge_to_arc_center_test: clean");
		else $display("bulge_to_arc_center_test: errors");
		$finish;
	end

	always @(posedge clk) begin
		if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
			timed_out = 1'b1;
			$display("bulge_to_arc_center_test: errors");
			$finish;
		end
	end

endmodule
`default_nettype wire
